FILE: hdl/mcms_pkg.sv
`default_nettype none

package mcms_pkg;

  localparam int unsigned PULSES_PER_QUARTER = 24;
  localparam int unsigned MAX_CATCHUP        = 8;

  // 3840000 / (ppq * bpm) == (3840000 / ppq) / bpm under floor division
  localparam int unsigned MASTER_NUM = 3840000 / PULSES_PER_QUARTER;
  localparam int unsigned SLAVE_NUM  = 60000 / PULSES_PER_QUARTER;

  localparam int unsigned DIV_W     = $clog2(MASTER_NUM + 1);
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);
  localparam int unsigned TICK_W    = $clog2(MAX_CATCHUP + 1);
  localparam int unsigned LIM_W     = DIV_W + $clog2(MAX_CATCHUP + 1);
  localparam int unsigned ITEMS_W   = TICK_W + 1;

  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 24;

  localparam int unsigned BPM_MIN = 20;
  localparam int unsigned BPM_MAX = 300;

  localparam logic [7:0] MIDI_START = 8'hFA;
  localparam logic [7:0] MIDI_CONT  = 8'hFB;
  localparam logic [7:0] MIDI_STOP  = 8'hFC;
  localparam logic [7:0] MIDI_TICK  = 8'hF8;
  localparam logic [7:0] MIDI_NONE  = 8'h00;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_MASTER = 2'd1;
  localparam logic [1:0] MODE_SLAVE  = 2'd2;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_RX    = 1'b1;

  localparam logic REG_SYNC_MODE = 1'b0;
  localparam logic REG_TEMPO     = 1'b1;

  localparam logic [9:0] TEMPO_RESET = 10'd120;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_UPDATE,
    ST_DIV_LD,
    ST_DIV,
    ST_POST,
    ST_COUNT,
    ST_EMIT
  } mcms_state_e;

  typedef struct packed {
    logic load;
    logic decode;
    logic update;
    logic div_start;
    logic post;
    logic count;
    logic emit;
  } mcms_cmd_t;

  typedef struct packed {
    logic need_calc;
    logic master;
    logic div_done;
    logic count_done;
    logic out_free;
    logic emit_last;
  } mcms_sts_t;

endpackage

`default_nettype wire

FILE: hdl/midi_clock_master_slave_core.sv
// Flow: a beat without a divide passes DECODE, then EMIT registers its first result beat once
// the output is free; a slave tempo measurement adds UPDATE, DIV_LD, DIV (18-step shared
// divider) and POST, a master frame tick also COUNT for the F8s to send. Later result beats
// follow while the output is free. One beat in flight; the next waits for the last result.
// Reset (rst_ni low, async): transport, accumulator and tempo history cleared,
// sync_mode 0, tempo_bpm 120.
`default_nettype none

module midi_clock_master_slave_core import mcms_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,  // now_ms, play_request, rx_byte
  input  wire logic [0:0]             s_axis_tuser,  // op
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata,  // tx_byte, running, notes_off,
                                                     // tempo_valid, measured_bpm
  output logic [0:0]                  m_axis_tuser,  // tx_valid
  output logic                        m_axis_tlast,
  input  wire logic                   psel,
  input  wire logic                   penable,
  input  wire logic                   pwrite,
  input  wire logic [2:0]             paddr,
  input  wire logic [31:0]            pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  logic [1:0] sync_mode_q;
  logic [9:0] tempo_bpm_q;
  mcms_cmd_t  cmd;
  mcms_sts_t  sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_mode_q <= MODE_OFF;
      tempo_bpm_q <= TEMPO_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_SYNC_MODE: sync_mode_q <= pwdata[1:0];
        REG_TEMPO:     tempo_bpm_q <= pwdata[9:0];
        default:       sync_mode_q <= sync_mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SYNC_MODE: prdata = 32'(sync_mode_q);
      REG_TEMPO:     prdata = 32'(tempo_bpm_q);
      default:       prdata = '0;
    endcase
  end

  mcms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mcms_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sync_mode_i (sync_mode_q),
    .tempo_bpm_i (tempo_bpm_q),
    .in_tdata_i  (s_axis_tdata),
    .in_tuser_i  (s_axis_tuser),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_tdata_o (m_axis_tdata),
    .out_tuser_o (m_axis_tuser),
    .out_tlast_o (m_axis_tlast)
  );

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("result emitted over a held beat");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while busy");

  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[7:0] == MIDI_NONE))
    else $error("byte on a beat with nothing to send");

  a_bpm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[10]) |->
      (m_axis_tdata[19:11] >= 9'(BPM_MIN) && m_axis_tdata[19:11] <= 9'(BPM_MAX)))
    else $error("reported tempo out of range");

endmodule

`default_nettype wire

FILE: hdl/mcms_div.sv
`default_nettype none

module mcms_div import mcms_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DIV_W-1:0] dividend_i,
  input  wire logic [31:0]      divisor_i,
  output logic                  done_o,
  output logic [DIV_W-1:0]      quotient_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]          rem_q;
  logic [31:0]          den_q;
  logic [DIV_W-1:0]     quo_q;
  logic [32:0]          trial;
  logic [32:0]          diff;
  logic                 fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    diff  = trial - {1'b0, den_q};
    fits  = trial >= {1'b0, den_q};
  end

  always_comb begin
    cnt_d = cnt_q;
    if (start_i) begin
      cnt_d = DIV_CNT_W'(DIV_W);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      den_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? diff[31:0] : trial[31:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o     = (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

FILE: hdl/mcms_ctrl.sv
`default_nettype none

module mcms_ctrl import mcms_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire mcms_sts_t sts_i,
  output mcms_cmd_t      cmd_o
);

  mcms_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_DECODE;
      ST_DECODE: state_d = sts_i.need_calc ? ST_UPDATE : ST_EMIT;
      ST_UPDATE: state_d = ST_DIV_LD;
      ST_DIV_LD: state_d = ST_DIV;
      ST_DIV:    if (sts_i.div_done) state_d = ST_POST;
      ST_POST:   state_d = sts_i.master ? ST_COUNT : ST_EMIT;
      ST_COUNT:  if (sts_i.count_done) state_d = ST_EMIT;
      ST_EMIT:   if (sts_i.out_free && sts_i.emit_last) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DECODE: cmd_o.decode    = 1'b1;
      ST_UPDATE: cmd_o.update    = 1'b1;
      ST_DIV_LD: cmd_o.div_start = 1'b1;
      ST_DIV:    cmd_o.load      = 1'b0;
      ST_POST:   cmd_o.post      = 1'b1;
      ST_COUNT:  cmd_o.count     = 1'b1;
      ST_EMIT:   cmd_o.emit      = sts_i.out_free;
      default:   cmd_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/mcms_dp.sv
`default_nettype none

module mcms_dp import mcms_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire mcms_cmd_t              cmd_i,
  output mcms_sts_t                   sts_o,
  input  wire logic [1:0]             sync_mode_i,
  input  wire logic [9:0]             tempo_bpm_i,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata_i,  // now_ms, play_request, rx_byte
  input  wire logic [0:0]             in_tuser_i,  // op
  input  wire logic                   out_ready_i,
  output logic                        out_valid_o,
  output logic [OUT_TDATA_W-1:0]      out_tdata_o, // tx_byte, running, notes_off,
                                                   // tempo_valid, measured_bpm
  output logic [0:0]                  out_tuser_o, // tx_valid
  output logic                        out_tlast_o
);

  // captured beat
  logic        op_q;
  logic [31:0] now_q;
  logic        play_q;
  logic [7:0]  rx_q;

  // architectural state
  logic        started_q;
  logic [31:0] last_frame_q;
  logic [31:0] acc_q;
  logic        slave_run_q;
  logic        saw_tick_q;
  logic [31:0] last_rx_q;
  logic [31:0] avg_q;
  logic [31:0] sample_q;

  // per-beat results
  logic              fa_q;
  logic              fc_q;
  logic [TICK_W-1:0] ntick_q;
  logic              notes_off_q;
  logic              tvalid_q;
  logic [8:0]        mbpm_q;

  // output register
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_tdata_q;
  logic                   out_txv_q;
  logic                   out_last_q;

  logic               is_master;
  logic               is_slave;
  logic               meas;
  logic [31:0]        elapsed;
  logic [31:0]        acc_sum;
  logic [32:0]        avg_sum;
  logic [31:0]        interval;
  logic [DIV_W-1:0]   dividend;
  logic [31:0]        divisor;
  logic [DIV_W-1:0]   quo;
  logic               div_done;
  logic [LIM_W-1:0]   limit;
  logic               acc_ge;
  logic               bpm_ok;
  logic [ITEMS_W-1:0] items;
  logic [7:0]         item_byte;
  logic               running;
  logic               out_free;

  always_comb begin
    is_master = (sync_mode_i == MODE_MASTER);
    is_slave  = (sync_mode_i == MODE_SLAVE);
    meas      = (last_rx_q != '0) && (now_q > last_rx_q);
    elapsed   = now_q - last_frame_q;
    acc_sum   = acc_q + {elapsed[25:0], 6'b0};
    avg_sum   = {1'b0, avg_q} + {1'b0, sample_q};
    interval  = (avg_q == '0) ? 32'd1 : avg_q;
    dividend  = is_master ? DIV_W'(MASTER_NUM) : DIV_W'(SLAVE_NUM);
    divisor   = is_master ? 32'(tempo_bpm_i) : interval;
    limit     = LIM_W'(quo) * LIM_W'(MAX_CATCHUP);
    acc_ge    = acc_q >= 32'(quo);
    bpm_ok    = (quo >= DIV_W'(BPM_MIN)) && (quo <= DIV_W'(BPM_MAX));
    items     = ITEMS_W'(fa_q) + ITEMS_W'(fc_q) + ITEMS_W'(ntick_q);
    if (fa_q) begin
      item_byte = MIDI_START;
    end else if (fc_q) begin
      item_byte = MIDI_STOP;
    end else if (ntick_q != '0) begin
      item_byte = MIDI_TICK;
    end else begin
      item_byte = MIDI_NONE;
    end
    running  = is_master ? started_q : (is_slave ? slave_run_q : 1'b0);
    out_free = !out_valid_q || out_ready_i;
  end

  mcms_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  always_comb begin
    sts_o.need_calc  = is_master ? (op_q == OP_FRAME && play_q && tempo_bpm_i != '0)
                                 : (is_slave && op_q == OP_FRAME && saw_tick_q && meas);
    sts_o.master     = is_master;
    sts_o.div_done   = div_done;
    sts_o.count_done = !acc_ge;
    sts_o.out_free   = out_free;
    sts_o.emit_last  = (items <= ITEMS_W'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      now_q  <= in_tdata_i[31:0];
      play_q <= in_tdata_i[32];
      rx_q   <= in_tdata_i[40:33];
      op_q   <= in_tuser_i[0];
    end
    if (cmd_i.decode && is_slave && op_q == OP_FRAME && saw_tick_q) begin
      sample_q <= now_q - last_rx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      last_frame_q <= '0;
      acc_q        <= '0;
      slave_run_q  <= 1'b0;
      saw_tick_q   <= 1'b0;
      last_rx_q    <= '0;
      avg_q        <= '0;
      fa_q         <= 1'b0;
      fc_q         <= 1'b0;
      ntick_q      <= '0;
      notes_off_q  <= 1'b0;
      tvalid_q     <= 1'b0;
      mbpm_q       <= '0;
    end else begin
      if (cmd_i.load) begin
        fa_q        <= 1'b0;
        fc_q        <= 1'b0;
        ntick_q     <= '0;
        notes_off_q <= 1'b0;
        tvalid_q    <= 1'b0;
        mbpm_q      <= '0;
      end
      if (cmd_i.decode) begin
        if (is_master && op_q == OP_FRAME) begin
          if (play_q) begin
            if (!started_q) begin
              started_q    <= 1'b1;
              last_frame_q <= now_q;
              acc_q        <= '0;
              fa_q         <= 1'b1;
            end
          end else begin
            if (started_q) begin
              started_q <= 1'b0;
              fc_q      <= 1'b1;
            end
            acc_q <= '0;
          end
        end
        if (is_slave) begin
          if (op_q == OP_RX) begin
            case (rx_q)
              MIDI_START, MIDI_CONT: slave_run_q <= 1'b1;
              MIDI_STOP: begin
                slave_run_q <= 1'b0;
                notes_off_q <= 1'b1;
              end
              MIDI_TICK: saw_tick_q <= 1'b1;
              default:   saw_tick_q <= saw_tick_q;
            endcase
          end else if (saw_tick_q) begin
            last_rx_q  <= now_q;
            saw_tick_q <= 1'b0;
          end
        end
      end
      if (cmd_i.update) begin
        if (is_master) begin
          acc_q        <= acc_sum;
          last_frame_q <= now_q;
        end else begin
          avg_q <= (avg_q == '0) ? sample_q : avg_sum[32:1];
        end
      end
      if (cmd_i.post) begin
        if (is_master) begin
          if (acc_q > 32'(limit)) begin
            acc_q <= '0;
          end
        end else if (bpm_ok) begin
          tvalid_q <= 1'b1;
          mbpm_q   <= quo[8:0];
        end
      end
      if (cmd_i.count && acc_ge) begin
        acc_q   <= acc_q - 32'(quo);
        ntick_q <= ntick_q + 1'b1;
      end
      if (cmd_i.emit) begin
        if (fa_q) begin
          fa_q <= 1'b0;
        end else if (fc_q) begin
          fc_q <= 1'b0;
        end else if (ntick_q != '0) begin
          ntick_q <= ntick_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_tdata_q <= {4'b0, mbpm_q, tvalid_q, notes_off_q, running, item_byte};
      out_txv_q   <= (items != '0);
      out_last_q  <= (items <= ITEMS_W'(1));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = out_tdata_q;
  assign out_tuser_o = out_txv_q;
  assign out_tlast_o = out_last_q;

endmodule

`default_nettype wire
